FILE: src/cera_pkg.sv
// Shared types and codes for the contiguous endpoint range allocator.
package cera_pkg;

  typedef enum logic [1:0] {
    ACT_FIND  = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_ALLOC = 2'd2,
    ACT_FREE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BEYOND    = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [5:0] first_entry;
    logic [6:0] run_length;
  } req_t;

  typedef struct packed {
    logic [6:0] start_index;
    logic       range_ok;
    status_t    status;
  } resp_t;

endpackage

FILE: src/cera_cell.sv
// One occupancy bit of the rotating endpoint map.
module cera_cell #(
  parameter logic RESET_VAL = 1'b0
) (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  logic d,
  output logic q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= RESET_VAL;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: src/contiguous_endpoint_range_allocator.sv
// Top level: rotating ring of occupancy cells with a bit-serial scan controller.
// A scanned request gives done after a full turn of the ring; a check, allocate
// or free whose range passes the end of the map answers in the next cycle. A new
// request is taken only while no scan runs, as the scan uses the single head cell
// the ring rotates past the controller; results cannot be stalled by the receiver.
// Reset: the low RESERVED_ENTRIES endpoints read used, all others free, block idle.
module contiguous_endpoint_range_allocator #(
  parameter int ENTRIES          = 64,
  parameter int RESERVED_ENTRIES = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cera_pkg::req_t req,
  output logic           done,
  output cera_pkg::resp_t resp
);

  import cera_pkg::*;

  localparam int PW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = ((CW > 7) ? CW : 7) + 1;

  logic [ENTRIES-1:0] occ;
  logic               head;
  logic               head_next;
  logic               shift;

  state_t        state, state_next;
  logic [PW-1:0] pos, pos_next;
  req_t          op, op_next;
  logic [CW-1:0] run_cnt, run_cnt_next;
  logic [PW-1:0] base, base_next;
  logic [PW-1:0] idx, idx_next;
  logic          found, found_next;
  logic          ok, ok_next;
  logic          unalloc, unalloc_next;
  logic          done_next;
  resp_t         resp_next;

  logic          accept;
  logic          beyond;
  logic          in_range;
  logic          last;

  assign head   = occ[0];
  assign shift  = (state == S_SCAN);
  assign accept = start && !busy;
  assign busy   = (state == S_SCAN);
  assign beyond = (LW'(req.first_entry) + LW'(req.run_length)) > LW'(ENTRIES);
  assign last   = (pos == PW'(ENTRIES - 1));
  assign in_range = (LW'(pos) >= LW'(op.first_entry)) &&
                    (LW'(pos) < (LW'(op.first_entry) + LW'(op.run_length)));

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic d;
      if (g == ENTRIES - 1) begin : g_tail
        assign d = head_next;
      end else begin : g_mid
        assign d = occ[g+1];
      end
      cera_cell #(
        .RESET_VAL(g < RESERVED_ENTRIES)
      ) u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .d    (d),
        .q    (occ[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    pos     <= pos_next;
    op      <= op_next;
    run_cnt <= run_cnt_next;
    base    <= base_next;
    idx     <= idx_next;
    found   <= found_next;
    ok      <= ok_next;
    unalloc <= unalloc_next;
    resp    <= resp_next;
  end

  always_comb begin
    state_next   = state;
    pos_next     = pos;
    op_next      = op;
    run_cnt_next = run_cnt;
    base_next    = base;
    idx_next     = idx;
    found_next   = found;
    ok_next      = ok;
    unalloc_next = unalloc;
    done_next    = 1'b0;
    resp_next    = resp;
    head_next    = head;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next      = req;
          pos_next     = '0;
          run_cnt_next = '0;
          base_next    = '0;
          idx_next     = '0;
          found_next   = 1'b0;
          ok_next      = 1'b1;
          unalloc_next = 1'b0;
          if (req.action != ACT_FIND && beyond) begin
            done_next             = 1'b1;
            resp_next.start_index = {1'b0, req.first_entry};
            resp_next.range_ok    = 1'b0;
            resp_next.status      = ST_BEYOND;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        case (op.action)
          ACT_FIND: begin
            if (!head) begin
              run_cnt_next = run_cnt + CW'(1);
              base_next    = (run_cnt == '0) ? pos : base;
              if (!found && ((LW'(run_cnt) + LW'(1)) >= LW'(op.run_length))) begin
                found_next = 1'b1;
                idx_next   = (run_cnt == '0) ? pos : base;
              end
            end else begin
              run_cnt_next = '0;
            end
          end
          ACT_CHECK: begin
            if (in_range && head) begin
              ok_next = 1'b0;
            end
          end
          ACT_ALLOC: begin
            if (in_range) begin
              head_next = 1'b1;
            end
          end
          ACT_FREE: begin
            if (in_range) begin
              head_next = 1'b0;
              if (!head) begin
                ok_next      = 1'b0;
                unalloc_next = 1'b1;
              end
            end
          end
          default: begin
            head_next = head;
          end
        endcase
        pos_next = pos + PW'(1);
        if (last) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (op.action == ACT_FIND) begin
            resp_next.start_index = found_next ? 7'(idx_next) : 7'(ENTRIES);
            resp_next.range_ok    = found_next;
            resp_next.status      = ST_OK;
          end else begin
            resp_next.start_index = {1'b0, op.first_entry};
            resp_next.range_ok    = ok_next;
            resp_next.status      = unalloc_next ? ST_NOT_ALLOC : ST_OK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_scan_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  a_scan_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && !(req.action != ACT_FIND && beyond)) |=> busy)
    else $error("in-range request did not start a scan");

  a_beyond_not_ok: assert property (@(posedge clk) disable iff (rst)
    (done && resp.status == ST_BEYOND) |-> !resp.range_ok)
    else $error("out-of-map range reported ok");

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    (done && resp.range_ok) |-> (resp.status == ST_OK))
    else $error("ok result carries an error status");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the contiguous endpoint range allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cera_pkg::*;

  localparam int ENTRIES          = 64;
  localparam int RESERVED_ENTRIES = 4;
  localparam int RANDOM_ITEMS     = 1100;
  localparam int LIMIT_CYCLES     = 600000;

  logic  clk = 1'b0;
  logic  rst;
  logic  start;
  logic  busy;
  req_t  req;
  logic  done;
  resp_t resp;

  contiguous_endpoint_range_allocator #(
    .ENTRIES          (ENTRIES),
    .RESERVED_ENTRIES (RESERVED_ENTRIES)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .resp  (resp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [ENTRIES-1:0] occupied;
  resp_t              awaited_resp[$];
  int unsigned        cycle_count = 0;
  int unsigned        error_count = 0;
  int unsigned        sent_count  = 0;
  int unsigned        resp_count  = 0;
  int unsigned        action_count[4];
  int unsigned        flagged_count = 0;
  int unsigned        burst_left = 0;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Timeout after %0d cycles, %0d transactions outstanding",
             cycle_count, awaited_resp.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("Result %0d: %s is %0d, expected %0d", resp_count, field, got, want);
    error_count++;
  endtask

  // Applies one request to the shadow occupancy map and returns the answer.
  function automatic resp_t apply_request(input req_t r);
    resp_t o;
    int    base;
    int    pos;
    int    lo;
    int    len;
    int    i;
    lo            = int'(r.first_entry);
    len           = int'(r.run_length);
    o.start_index = 7'(lo);
    o.range_ok    = 1'b1;
    o.status      = ST_OK;
    if (r.action == ACT_FIND) begin
      base = ENTRIES;
      for (i = ENTRIES - 1; i >= 0; i--)
        if (!occupied[i]) base = i;
      pos = base;
      while (pos < base + len && pos < ENTRIES) begin
        if (occupied[pos]) base = pos + 1;
        pos++;
      end
      if (pos != base + len) base = ENTRIES;
      o.start_index = 7'(base);
      o.range_ok    = (base != ENTRIES);
    end else if (lo + len > ENTRIES) begin
      o.range_ok = 1'b0;
      o.status   = ST_BEYOND;
    end else begin
      for (i = lo; i < lo + len; i++) begin
        case (r.action)
          ACT_CHECK: begin
            if (occupied[i]) o.range_ok = 1'b0;
          end
          ACT_ALLOC: begin
            occupied[i] = 1'b1;
          end
          default: begin
            if (!occupied[i]) begin
              o.range_ok = 1'b0;
              o.status   = ST_NOT_ALLOC;
            end
            occupied[i] = 1'b0;
          end
        endcase
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (!rst && done) begin
      if (awaited_resp.size() == 0) begin
        $display("Result %0d arrived with no transaction outstanding", resp_count);
        error_count++;
      end else begin
        want = awaited_resp.pop_front();
        if (resp.start_index !== want.start_index)
          report_mismatch("start_index", int'(resp.start_index), int'(want.start_index));
        if (resp.range_ok !== want.range_ok)
          report_mismatch("range_ok", int'(resp.range_ok), int'(want.range_ok));
        if (resp.status !== want.status)
          report_mismatch("status", int'(resp.status), int'(want.status));
      end
      resp_count++;
    end
  end

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Keeps start high within a burst; drops it for a random gap between bursts.
  task automatic send_req(input action_t act, input int first, input int len,
                          output resp_t predicted);
    req_t r;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(20, 80));
      else hold_off($urandom_range(1, 4));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    r.action      = act;
    r.first_entry = 6'(first);
    r.run_length  = 7'(len);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    predicted = apply_request(r);
    awaited_resp.push_back(predicted);
    sent_count++;
    action_count[act]++;
    if (predicted.status != ST_OK) flagged_count++;
  endtask

  task automatic test_reset_map();
    resp_t p;
    send_req(ACT_FIND,  0, 0,   p);
    send_req(ACT_CHECK, 0, RESERVED_ENTRIES, p);
    send_req(ACT_CHECK, RESERVED_ENTRIES, ENTRIES - RESERVED_ENTRIES, p);
    send_req(ACT_FIND,  63, 64, p);
    send_req(ACT_FIND,  0, 60,  p);
    send_req(ACT_FIND,  0, 65,  p);
    send_req(ACT_FIND,  63, 127, p);
  endtask

  task automatic test_range_edges();
    resp_t p;
    send_req(ACT_CHECK, 63, 1,   p);
    send_req(ACT_CHECK, 63, 2,   p);
    send_req(ACT_ALLOC, 63, 0,   p);
    send_req(ACT_FREE,  0,  0,   p);
    send_req(ACT_CHECK, 0,  0,   p);
    send_req(ACT_ALLOC, 60, 5,   p);
    send_req(ACT_FREE,  63, 127, p);
    send_req(ACT_CHECK, 0,  64,  p);
  endtask

  task automatic test_full_map();
    resp_t p;
    send_req(ACT_ALLOC, RESERVED_ENTRIES, ENTRIES - RESERVED_ENTRIES, p);
    send_req(ACT_FIND,  0,  0,  p);
    send_req(ACT_FIND,  0,  1,  p);
    send_req(ACT_ALLOC, 10, 5,  p);
    send_req(ACT_FREE,  0,  64, p);
  endtask

  task automatic test_free_flags();
    resp_t p;
    send_req(ACT_FREE,  0,  1, p);
    send_req(ACT_ALLOC, 20, 3, p);
    send_req(ACT_FREE,  18, 6, p);
    send_req(ACT_FIND,  0,  0, p);
    send_req(ACT_ALLOC, 0,  2, p);
    send_req(ACT_ALLOC, 5,  1, p);
    send_req(ACT_FIND,  0,  3, p);
    send_req(ACT_FIND,  0,  4, p);
  endtask

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 6);
    if (roll < 95) return $urandom_range(7, 32);
    return $urandom_range(33, 64);
  endfunction

  // Mostly find-then-claim and free of held ranges, with checks and noise.
  task automatic test_random_traffic(input int count);
    resp_t p;
    int    held_first[$];
    int    held_len[$];
    int    stop_at;
    int    roll;
    int    len;
    int    first;
    int    k;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        len = pick_length();
        send_req(ACT_FIND, $urandom_range(0, 63), len, p);
        if (p.range_ok && len > 0 && $urandom_range(0, 9) != 0) begin
          send_req(ACT_ALLOC, int'(p.start_index), len, p);
          held_first.push_back(int'(p.start_index));
          held_len.push_back(len);
        end
      end else if (roll < 60 && held_first.size() > 0) begin
        k = $urandom_range(0, held_first.size() - 1);
        send_req(ACT_FREE, held_first[k], held_len[k], p);
        held_first.delete(k);
        held_len.delete(k);
      end else if (roll < 72) begin
        len   = pick_length();
        first = $urandom_range(0, ENTRIES - (len > 0 ? len : 1));
        send_req(ACT_CHECK, first, len, p);
      end else if (roll < 80 && held_first.size() > 0) begin
        k = $urandom_range(0, held_first.size() - 1);
        send_req(ACT_CHECK, held_first[k], held_len[k], p);
      end else if (roll < 98) begin
        send_req(action_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                 $urandom_range(0, 64), p);
      end else begin
        send_req(ACT_FREE, 0, ENTRIES, p);
        held_first.delete();
        held_len.delete();
      end
    end
  endtask

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    occupied = '0;
    for (int i = 0; i < RESERVED_ENTRIES; i++) occupied[i] = 1'b1;
    foreach (action_count[i]) action_count[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_map();
    test_range_edges();
    test_full_map();
    test_free_flags();
    test_random_traffic(RANDOM_ITEMS);

    start <= 1'b0;
    while (awaited_resp.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Sent %0d requests (find %0d, check %0d, allocate %0d, free %0d)",
             sent_count, action_count[ACT_FIND], action_count[ACT_CHECK],
             action_count[ACT_ALLOC], action_count[ACT_FREE]);
    $display("Checked %0d results, %0d flagged, %0d mismatches",
             resp_count, flagged_count, error_count);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
src/cera_pkg.sv
src/cera_cell.sv
src/contiguous_endpoint_range_allocator.sv
dv/tb.sv
